>>> hw/rtl/stl_pkg.sv
// Shared types, codes and keyword table for the source token lexer.
// Used by stl_ctrl, stl_dp and source_token_lexer; depends on nothing.
package stl_pkg;

   localparam int SYMBOLS_DEF  = 64;
   localparam int WORD_MAX_DEF = 32;
   localparam int KW_COUNT     = 15;
   localparam int KW_MAX_LEN   = 8;
   localparam int CSR_ADDR_W   = 3;
   localparam int QUEUE_DEPTH  = 4;

   // configuration register addresses
   localparam logic [CSR_ADDR_W-1:0] CSR_START_ID = 3'd0;
   localparam logic [15:0] START_ID_RESET = 16'd100;

   localparam logic [30:0] VALUE_MAX = 31'h7fff_ffff;

   // token kinds
   localparam logic [2:0] KIND_KEYWORD  = 3'd0;
   localparam logic [2:0] KIND_IDENT    = 3'd1;
   localparam logic [2:0] KIND_NUMBER   = 3'd2;
   localparam logic [2:0] KIND_STR_BYTE = 3'd3;
   localparam logic [2:0] KIND_STR_END  = 3'd4;
   localparam logic [2:0] KIND_DELIM    = 3'd5;
   localparam logic [2:0] KIND_OPERATOR = 3'd6;
   localparam logic [2:0] KIND_ERROR    = 3'd7;

   // error codes
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_BAD_CHAR  = 2'd1;
   localparam logic [1:0] ERR_WORD_LONG = 2'd2;
   localparam logic [1:0] ERR_TAB_FULL  = 2'd3;

   typedef struct packed {
      logic [7:0] byte_req;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [2:0]  token_kind;
      logic [30:0] tok_value;
      logic [7:0]  first_char;
      logic [7:0]  second_char;
      logic [1:0]  error_code;
      logic        last;
   } rsp_type;

   // where the token value of a queued item comes from
   typedef enum logic [2:0] {
      VS_LIT,
      VS_NUM,
      VS_STR,
      VS_KW,
      VS_ID
   } vsel_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] kind;
      vsel_type   vsel;
      logic [7:0] lit;
      logic [7:0] c1;
      logic [7:0] c2;
      logic [1:0] err;
   } emit_type;

   typedef struct packed {
      emit_type   emit0;
      emit_type   emit1;
      logic [7:0] byte_val;
      logic       word_start;
      logic       word_add;
      logic       num_start;
      logic       num_add;
      logic       str_start;
      logic       str_add;
      logic       sym_first;
      logic       sym_next;
      logic       len_rd;
      logic       txt_rd;
      logic       j_clr;
      logic       j_inc;
      logic       ins_wr;
      logic       ins_len;
      logic       cnt_inc;
   } cmd_type;

   typedef struct packed {
      logic kw_hit;
      logic sym_end;
      logic table_full;
      logic len_eq;
      logic byte_eq;
      logic last_byte;
      logic word_room;
      logic q_room;
   } stat_type;

   // keyword text, byte j at bits [8j+7:8j]
   function automatic logic [63:0] kw_word(input logic [3:0] idx);
      logic [63:0] w;
      begin
         case (idx)
            4'd0:    w = {8'd0, "regetni"};
            4'd1:    w = {32'd0, "rahc"};
            4'd2:    w = {48'd0, "fi"};
            4'd3:    w = {32'd0, "esle"};
            4'd4:    w = {24'd0, "elihw"};
            4'd5:    w = {40'd0, "rof"};
            4'd6:    w = {16'd0, "nruter"};
            4'd7:    w = {32'd0, "diov"};
            4'd8:    w = {8'd0, "naeloob"};
            4'd9:    w = {24'd0, "yarra"};
            4'd10:   w = {24'd0, "eslaf"};
            4'd11:   w = {32'd0, "eurt"};
            4'd12:   w = "noitcnuf";
            4'd13:   w = {24'd0, "tnirp"};
            4'd14:   w = {16'd0, "gnirts"};
            default: w = 64'd0;
         endcase
         return w;
      end
   endfunction

   function automatic logic [3:0] kw_length(input logic [3:0] idx);
      logic [3:0] n;
      begin
         case (idx)
            4'd0, 4'd8:                     n = 4'd7;
            4'd1, 4'd3, 4'd7, 4'd11:        n = 4'd4;
            4'd2:                           n = 4'd2;
            4'd4, 4'd9, 4'd10, 4'd13:       n = 4'd5;
            4'd5:                           n = 4'd3;
            4'd6, 4'd14:                    n = 4'd6;
            4'd12:                          n = 4'd8;
            default:                        n = 4'd0;
         endcase
         return n;
      end
   endfunction

endpackage

>>> hw/rtl/source_token_lexer.sv
// Source token lexer: takes one source byte per item on req_, gives tokens
// on rsp_, start_id on an APB-style csr_ port.
// Each accepted byte gives zero, one or two result items; the final one of
// an input carries last. Results pass through a four-entry queue, so
// results are registered and input goes on while the receiver stalls,
// as long as two queue entries are free.
// Throughput: one byte per cycle while two queue entries are free, except
// at the end of a word. A keyword is checked, then emitted. An identifier
// walks the symbol table, reading one stored length at a time and, for
// symbols of equal length, comparing one byte at a time; a new identifier
// is then copied in at one byte per cycle. The single-port symbol text
// memory paces this search.
// Reset empties the symbol table and the queue, returns the scanner to its
// idle mode and sets start_id to 100; no clearing pass is needed.
// Write start_id only while the block is idle.
module source_token_lexer #(
   parameter int SYMBOLS  = stl_pkg::SYMBOLS_DEF,
   parameter int WORD_MAX = stl_pkg::WORD_MAX_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  stl_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output stl_pkg::rsp_type               rsp_data,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [stl_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import stl_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // scanner and search sequencing
   stl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat)
   );

   // storage, symbol table and result queue
   stl_dp #(
      .SYMBOLS  (SYMBOLS),
      .WORD_MAX (WORD_MAX)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

>>> hw/rtl/stl_ctrl.sv
// Scanner and symbol search state machine of the source token lexer.
// Depends on stl_pkg; drives stl_dp through cmd and reads its status.
module stl_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  stl_pkg::req_type req_data,
   output stl_pkg::cmd_type cmd,
   input  stl_pkg::stat_type stat
);
   import stl_pkg::*;

   typedef enum logic [3:0] {
      M_IDLE, M_WORD, M_WORD_LONG, M_NUMBER, M_STRING, M_SLASH,
      M_LINE, M_BLOCK, M_BLOCK_STAR, M_OP
   } mode_type;

   typedef enum logic [2:0] {
      S_RUN, S_KW, S_SYM, S_LEN, S_CMPRD, S_CMP, S_INS, S_FIN
   } state_type;

   typedef enum logic [1:0] {F_KW, F_ID, F_FULL} fin_type;

   typedef struct packed {
      mode_type mode;
      emit_type em;
      logic     word_start;
      logic     num_start;
      logic     str_start;
      logic     set_pend;
   } idle_type;

   state_type  state_ff, state_in;
   mode_type   mode_ff, mode_in;
   fin_type    fin_ff, fin_in;
   logic [7:0] pend_ff, pend_in;
   logic [7:0] save_c_ff, save_c_in;
   logic       save_e_ff, save_e_in;

   function automatic emit_type mk(input logic [2:0] kind, input vsel_type vs,
                                   input logic [7:0] lit, input logic [7:0] c1,
                                   input logic [7:0] c2, input logic [1:0] err);
      emit_type e;
      begin
         e.valid = 1'b1;
         e.kind  = kind;
         e.vsel  = vs;
         e.lit   = lit;
         e.c1    = c1;
         e.c2    = c2;
         e.err   = err;
         return e;
      end
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   // decode a byte seen with nothing pending
   function automatic idle_type idle_byte(input logic [7:0] c);
      idle_type r;
      begin
         r = '0;
         r.mode = M_IDLE;
         if (c == " " || c == "\n" || c == "\t") begin
            r.mode = M_IDLE;
         end else if (is_alpha(c)) begin
            r.word_start = 1'b1;
            r.mode = M_WORD;
         end else if (is_digit(c)) begin
            r.num_start = 1'b1;
            r.mode = M_NUMBER;
         end else if (c == "\"") begin
            r.str_start = 1'b1;
            r.mode = M_STRING;
         end else if (c == "/") begin
            r.mode = M_SLASH;
         end else if (c == "(" || c == ")" || c == "[" || c == "]" || c == "{" ||
                      c == "}" || c == "," || c == ";" || c == ":" || c == "'") begin
            r.em = mk(KIND_DELIM, VS_LIT, 8'd0, c, 8'd0, ERR_NONE);
         end else if (c == "+" || c == "-" || c == "=" || c == "&" || c == "|" ||
                      c == "<" || c == ">" || c == "!") begin
            r.set_pend = 1'b1;
            r.mode = M_OP;
         end else if (c == "*" || c == "%" || c == "^") begin
            r.em = mk(KIND_OPERATOR, VS_LIT, 8'd0, c, 8'd0, ERR_NONE);
         end else begin
            r.em = mk(KIND_ERROR, VS_LIT, 8'd0, 8'd0, 8'd0, ERR_BAD_CHAR);
         end
         return r;
      end
   endfunction

   logic       accept;
   logic [7:0] c;
   logic       eoi;
   logic       use_idle;
   logic       pair;
   logic       cmp_op;
   idle_type   idl;
   emit_type   em_a;
   emit_type   em_b;

   assign req_ready = (state_ff == S_RUN) && stat.q_room;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      fin_in    = fin_ff;
      pend_in   = pend_ff;
      save_c_in = save_c_ff;
      save_e_in = save_e_ff;
      cmd       = '0;
      em_a      = '0;
      em_b      = '0;
      use_idle  = 1'b0;
      c         = (state_ff == S_FIN) ? save_c_ff : req_data.byte_req;
      eoi       = req_data.end_of_input;
      idl       = idle_byte(c);
      cmp_op    = (pend_ff == "<") || (pend_ff == ">") || (pend_ff == "!");
      pair      = (cmp_op && c == "=") || (!cmp_op && c == pend_ff);

      case (state_ff)
         // scan one byte per cycle while two queue entries are free
         S_RUN: begin
            if (accept && eoi) begin
               mode_in = M_IDLE;
               case (mode_ff)
                  M_WORD: begin
                     save_e_in = 1'b1;
                     state_in  = S_KW;
                  end
                  M_WORD_LONG:
                     em_a = mk(KIND_ERROR, VS_LIT, 8'd0, 8'd0, 8'd0, ERR_WORD_LONG);
                  M_NUMBER:
                     em_a = mk(KIND_NUMBER, VS_NUM, 8'd0, 8'd0, 8'd0, ERR_NONE);
                  M_STRING:
                     em_a = mk(KIND_STR_END, VS_STR, 8'd0, 8'd0, 8'd0, ERR_NONE);
                  M_SLASH:
                     em_a = mk(KIND_OPERATOR, VS_LIT, 8'd0, "/", 8'd0, ERR_NONE);
                  M_OP:
                     em_a = mk(KIND_OPERATOR, VS_LIT, 8'd0, pend_ff, 8'd0, ERR_NONE);
                  default: ;
               endcase
            end else if (accept) begin
               case (mode_ff)
                  M_WORD, M_WORD_LONG: begin
                     if (is_alpha(c) || is_digit(c) || c == "_") begin
                        if (mode_ff == M_WORD && stat.word_room) begin
                           cmd.word_add = 1'b1;
                        end else begin
                           mode_in = M_WORD_LONG;
                        end
                     end else if (mode_ff == M_WORD_LONG) begin
                        em_a = mk(KIND_ERROR, VS_LIT, 8'd0, 8'd0, 8'd0, ERR_WORD_LONG);
                        use_idle = 1'b1;
                     end else begin
                        save_c_in = c;
                        save_e_in = 1'b0;
                        state_in  = S_KW;
                     end
                  end
                  M_NUMBER: begin
                     if (is_digit(c)) begin
                        cmd.num_add = 1'b1;
                     end else begin
                        em_a = mk(KIND_NUMBER, VS_NUM, 8'd0, 8'd0, 8'd0, ERR_NONE);
                        use_idle = 1'b1;
                     end
                  end
                  M_STRING: begin
                     if (c == "\"") begin
                        em_a = mk(KIND_STR_END, VS_STR, 8'd0, 8'd0, 8'd0, ERR_NONE);
                        mode_in = M_IDLE;
                     end else begin
                        em_a = mk(KIND_STR_BYTE, VS_LIT, c, 8'd0, 8'd0, ERR_NONE);
                        cmd.str_add = 1'b1;
                     end
                  end
                  M_SLASH: begin
                     if (c == "/") begin
                        mode_in = M_LINE;
                     end else if (c == "*") begin
                        mode_in = M_BLOCK;
                     end else begin
                        em_a = mk(KIND_OPERATOR, VS_LIT, 8'd0, "/", 8'd0, ERR_NONE);
                        use_idle = 1'b1;
                     end
                  end
                  M_LINE: begin
                     if (c == "\n") mode_in = M_IDLE;
                  end
                  M_BLOCK: begin
                     if (c == "*") mode_in = M_BLOCK_STAR;
                  end
                  M_BLOCK_STAR: begin
                     if (c == "/") begin
                        mode_in = M_IDLE;
                     end else if (c != "*") begin
                        mode_in = M_BLOCK;
                     end
                  end
                  M_OP: begin
                     if (pair) begin
                        em_a = mk(KIND_OPERATOR, VS_LIT, 8'd0, pend_ff, c, ERR_NONE);
                        mode_in = M_IDLE;
                     end else begin
                        em_a = mk(KIND_OPERATOR, VS_LIT, 8'd0, pend_ff, 8'd0, ERR_NONE);
                        use_idle = 1'b1;
                     end
                  end
                  default: use_idle = 1'b1;
               endcase
            end
         end
         // keyword check on the finished word
         S_KW: begin
            if (stat.kw_hit) begin
               fin_in   = F_KW;
               state_in = S_FIN;
            end else begin
               cmd.sym_first = 1'b1;
               state_in = S_SYM;
            end
         end
         // walk the symbol table
         S_SYM: begin
            if (stat.sym_end) begin
               if (stat.table_full) begin
                  fin_in   = F_FULL;
                  state_in = S_FIN;
               end else begin
                  cmd.j_clr = 1'b1;
                  state_in  = S_INS;
               end
            end else begin
               cmd.len_rd = 1'b1;
               state_in = S_LEN;
            end
         end
         S_LEN: begin
            if (stat.len_eq) begin
               cmd.j_clr = 1'b1;
               state_in  = S_CMPRD;
            end else begin
               cmd.sym_next = 1'b1;
               state_in = S_SYM;
            end
         end
         S_CMPRD: begin
            cmd.txt_rd = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (!stat.byte_eq) begin
               cmd.sym_next = 1'b1;
               state_in = S_SYM;
            end else if (stat.last_byte) begin
               fin_in   = F_ID;
               state_in = S_FIN;
            end else begin
               cmd.j_inc = 1'b1;
               state_in  = S_CMPRD;
            end
         end
         // copy the new identifier into the table
         S_INS: begin
            cmd.ins_wr = 1'b1;
            if (stat.last_byte) begin
               cmd.ins_len = 1'b1;
               cmd.cnt_inc = 1'b1;
               fin_in   = F_ID;
               state_in = S_FIN;
            end else begin
               cmd.j_inc = 1'b1;
            end
         end
         // emit the word token and handle the byte that ended it
         S_FIN: begin
            case (fin_ff)
               F_KW:    em_a = mk(KIND_KEYWORD, VS_KW, 8'd0, 8'd0, 8'd0, ERR_NONE);
               F_ID:    em_a = mk(KIND_IDENT, VS_ID, 8'd0, 8'd0, 8'd0, ERR_NONE);
               default: em_a = mk(KIND_ERROR, VS_LIT, 8'd0, 8'd0, 8'd0, ERR_TAB_FULL);
            endcase
            mode_in = M_IDLE;
            if (!save_e_ff) use_idle = 1'b1;
            state_in = S_RUN;
         end
         default: state_in = S_RUN;
      endcase

      if (use_idle) begin
         mode_in        = idl.mode;
         em_b           = idl.em;
         cmd.word_start = idl.word_start;
         cmd.num_start  = idl.num_start;
         cmd.str_start  = idl.str_start;
         if (idl.set_pend) pend_in = c;
      end

      // pack results so that a single one sits in the first slot
      cmd.byte_val = c;
      if (em_a.valid) begin
         cmd.emit0 = em_a;
         cmd.emit1 = em_b;
      end else begin
         cmd.emit0 = em_b;
         cmd.emit1 = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_RUN;
         mode_ff   <= M_IDLE;
         fin_ff    <= F_KW;
         pend_ff   <= 8'd0;
         save_c_ff <= 8'd0;
         save_e_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         mode_ff   <= mode_in;
         fin_ff    <= fin_in;
         pend_ff   <= pend_in;
         save_c_ff <= save_c_in;
         save_e_ff <= save_e_in;
      end
   end

endmodule

>>> hw/rtl/stl_dp.sv
// Datapath of the source token lexer: word buffer, accumulators, symbol
// memories, result queue and configuration register. Depends on stl_pkg.
module stl_dp #(
   parameter int SYMBOLS  = stl_pkg::SYMBOLS_DEF,
   parameter int WORD_MAX = stl_pkg::WORD_MAX_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [stl_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready,
   input  stl_pkg::cmd_type                cmd,
   output stl_pkg::stat_type               stat,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output stl_pkg::rsp_type                rsp_data
);
   import stl_pkg::*;

   localparam int WIDX_W  = $clog2(WORD_MAX);
   localparam int WLEN_W  = $clog2(WORD_MAX + 1);
   localparam int SIDX_W  = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
   localparam int SCNT_W  = $clog2(SYMBOLS + 1);
   localparam int TDEPTH  = SYMBOLS * WORD_MAX;
   localparam int TADDR_W = $clog2(TDEPTH);
   localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

   logic [15:0]       start_id_ff;
   logic [7:0]        wb_ff [WORD_MAX];
   logic [WLEN_W-1:0] wlen_ff;
   logic [30:0]       num_ff;
   logic [30:0]       str_ff;
   logic [7:0]        text_mem [TDEPTH];
   logic [WLEN_W-1:0] slen_mem [SYMBOLS];
   logic [SCNT_W-1:0] sym_cnt_ff;
   logic [SCNT_W-1:0] sym_i_ff;
   logic [WIDX_W-1:0] j_ff;
   logic [WLEN_W-1:0] len_rd_ff;
   logic [7:0]        txt_rd_ff;
   rsp_type           q_mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff;
   logic [QPTR_W-1:0] rd_ff;
   logic [QCNT_W-1:0] qcnt_ff;

   logic [SIDX_W-1:0]  sidx;
   logic [TADDR_W-1:0] taddr;
   logic [34:0]        num_prod;
   logic [14:0]        kw_hits;
   logic [3:0]         kw_idx;
   logic               csr_wr;
   rsp_type            r0;
   rsp_type            r1;
   logic               pop;
   logic [QCNT_W-1:0]  push_n;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr == CSR_START_ID) ? {16'd0, start_id_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_id_ff <= START_ID_RESET;
      end else if (csr_wr && csr_paddr == CSR_START_ID) begin
         start_id_ff <= csr_pwdata[15:0];
      end
   end

   // keyword match against the first bytes of the word
   always_comb begin
      logic [63:0] kw;
      logic        ok;
      kw_idx = 4'd0;
      for (int k = 0; k < KW_COUNT; k++) begin
         kw = kw_word(4'(k));
         ok = (wlen_ff == WLEN_W'(kw_length(4'(k))));
         for (int b = 0; b < KW_MAX_LEN; b++) begin
            if (b < int'(kw_length(4'(k))) && wb_ff[b] != kw[8*b +: 8]) ok = 1'b0;
         end
         kw_hits[k] = ok;
      end
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (kw_hits[k]) kw_idx = 4'(k);
      end
   end

   // word, number and string accumulators
   assign num_prod = {4'd0, num_ff} * 35'd10 + {31'd0, cmd.byte_val[3:0]};

   always_ff @(posedge clock) begin
      if (cmd.word_start) begin
         wb_ff[0] <= cmd.byte_val;
         wlen_ff  <= WLEN_W'(1);
      end else if (cmd.word_add) begin
         wb_ff[wlen_ff[WIDX_W-1:0]] <= cmd.byte_val;
         wlen_ff <= wlen_ff + WLEN_W'(1);
      end
      if (cmd.num_start) begin
         num_ff <= {27'd0, cmd.byte_val[3:0]};
      end else if (cmd.num_add) begin
         num_ff <= (num_prod > {4'd0, VALUE_MAX}) ? VALUE_MAX : num_prod[30:0];
      end
      if (cmd.str_start) begin
         str_ff <= 31'd0;
      end else if (cmd.str_add && str_ff != VALUE_MAX) begin
         str_ff <= str_ff + 31'd1;
      end
   end

   // symbol table walk
   assign sidx  = sym_i_ff[SIDX_W-1:0];
   assign taddr = TADDR_W'(sidx) * TADDR_W'(WORD_MAX) + TADDR_W'(j_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_cnt_ff <= '0;
      end else if (cmd.cnt_inc) begin
         sym_cnt_ff <= sym_cnt_ff + SCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sym_first) begin
         sym_i_ff <= '0;
      end else if (cmd.sym_next) begin
         sym_i_ff <= sym_i_ff + SCNT_W'(1);
      end
      if (cmd.j_clr) begin
         j_ff <= '0;
      end else if (cmd.j_inc) begin
         j_ff <= j_ff + WIDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ins_wr) text_mem[taddr] <= wb_ff[j_ff];
      if (cmd.txt_rd) txt_rd_ff <= text_mem[taddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.ins_len) slen_mem[sidx] <= wlen_ff;
      if (cmd.len_rd) len_rd_ff <= slen_mem[sidx];
   end

   // status back to the controller
   assign stat.kw_hit     = |kw_hits;
   assign stat.sym_end    = sym_i_ff >= sym_cnt_ff;
   assign stat.table_full = sym_cnt_ff >= SCNT_W'(SYMBOLS);
   assign stat.len_eq     = len_rd_ff == wlen_ff;
   assign stat.byte_eq    = txt_rd_ff == wb_ff[j_ff];
   assign stat.last_byte  = (WLEN_W'(j_ff) + WLEN_W'(1)) == wlen_ff;
   assign stat.word_room  = wlen_ff < WLEN_W'(WORD_MAX);
   assign stat.q_room     = qcnt_ff <= QCNT_W'(QUEUE_DEPTH - 2);

   // build result items from the controller's descriptors
   function automatic logic [30:0] pick_value(input emit_type e);
      logic [30:0] v;
      begin
         case (e.vsel)
            VS_LIT:  v = {23'd0, e.lit};
            VS_NUM:  v = num_ff;
            VS_STR:  v = str_ff;
            VS_KW:   v = {27'd0, kw_idx};
            VS_ID:   v = {15'd0, start_id_ff} + 31'(sym_i_ff);
            default: v = 31'd0;
         endcase
         return v;
      end
   endfunction

   always_comb begin
      r0.token_kind  = cmd.emit0.kind;
      r0.tok_value   = pick_value(cmd.emit0);
      r0.first_char  = cmd.emit0.c1;
      r0.second_char = cmd.emit0.c2;
      r0.error_code  = cmd.emit0.err;
      r0.last        = !cmd.emit1.valid;
      r1.token_kind  = cmd.emit1.kind;
      r1.tok_value   = pick_value(cmd.emit1);
      r1.first_char  = cmd.emit1.c1;
      r1.second_char = cmd.emit1.c2;
      r1.error_code  = cmd.emit1.err;
      r1.last        = 1'b1;
   end

   // result queue: up to two pushes, one pop per cycle
   assign rsp_valid = qcnt_ff != '0;
   assign rsp_data  = q_mem[rd_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign push_n    = QCNT_W'(cmd.emit0.valid) + QCNT_W'(cmd.emit1.valid);

   always_ff @(posedge clock) begin
      if (cmd.emit0.valid) q_mem[wr_ff] <= r0;
      if (cmd.emit1.valid) q_mem[wr_ff + QPTR_W'(1)] <= r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         qcnt_ff <= '0;
      end else begin
         wr_ff   <= wr_ff + QPTR_W'(push_n);
         if (pop) rd_ff <= rd_ff + QPTR_W'(1);
         qcnt_ff <= qcnt_ff + push_n - QCNT_W'(pop);
      end
   end

endmodule
